/* sv/spmv_pkg.sv */
// Shared types and constants of the CSR sparse matrix-vector multiplier.
`default_nettype none

package spmv_pkg;

   localparam int VECTOR_DEPTH_DEFAULT = 4096;
   localparam int QUEUE_DEPTH          = 4;

   localparam int OP_W      = 2;
   localparam int INDEX_W   = 12;
   localparam int VALUE_W   = 32;
   localparam int COLUMNS_W = 13;
   localparam int ROW_W     = 20;
   localparam int ACC_W     = 64;
   localparam int FRAC_W    = 16;

   localparam logic [COLUMNS_W-1:0] COLUMNS_RESET = 13'h1000;

   // Byte address bit that selects a register slot; register 0 sits at slot 0.
   localparam int  PADDR_W      = 3;
   localparam logic REG_COLUMNS = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_NONZERO = 2'd1,
      OP_EMPTY   = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_MAC   = 2'd1,
      KIND_SKIP  = 2'd2,
      KIND_EMPTY = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic                 fin;
      logic [INDEX_W-1:0]   index;
      logic [VALUE_W-1:0]   value;
   } entry_type;

endpackage

`default_nettype wire

/* sv/spmv_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module spmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sv/spmv_front.sv */
// Front end: decodes and classifies each accepted item for the queue.
`default_nettype none

module spmv_front #(
   parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEFAULT
) (
   input  wire logic [spmv_pkg::COLUMNS_W-1:0] columns_in_use,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [spmv_pkg::OP_W-1:0]      req_operation,
   input  wire logic [spmv_pkg::INDEX_W-1:0]   req_index,
   input  wire logic [spmv_pkg::VALUE_W-1:0]   req_value,
   input  wire logic                           req_row_end,
   input  wire logic                           queue_full,
   output logic                                push,
   output spmv_pkg::entry_type                 entry
);

   import spmv_pkg::*;

   localparam logic [16:0] DEPTH_LIMIT = 17'(VECTOR_DEPTH);

   logic [16:0] index_wide;
   logic        in_store;
   logic        in_columns;
   logic        keep;

   assign req_stall  = queue_full;
   assign index_wide = 17'(req_index);
   assign in_store   = index_wide < DEPTH_LIMIT;
   assign in_columns = 13'(req_index) < columns_in_use;

   always_comb begin
      entry.kind  = KIND_LOAD;
      entry.fin   = 1'b0;
      entry.index = req_index;
      entry.value = req_value;
      keep        = 1'b0;
      case (op_type'(req_operation))
         OP_LOAD: begin
            entry.kind = KIND_LOAD;
            keep       = in_store;
         end
         OP_NONZERO: begin
            entry.kind = (in_store && in_columns) ? KIND_MAC : KIND_SKIP;
            entry.fin  = req_row_end;
            keep       = 1'b1;
         end
         OP_EMPTY: begin
            entry.kind = KIND_EMPTY;
            entry.fin  = 1'b1;
            keep       = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = req_valid && !queue_full && keep;

endmodule

`default_nettype wire

/* sv/spmv_queue.sv */
// Short queue of classified items between the front and back ends.
`default_nettype none

module spmv_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire spmv_pkg::entry_type push_entry,
   input  wire logic          pop,
   output logic               not_empty,
   output logic               full,
   output spmv_pkg::entry_type head
);

   import spmv_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign not_empty = count_ff != '0;
   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* sv/spmv_back.sv */
// Back end: vector store access, multiply, saturating accumulate, row output.
`default_nettype none

module spmv_back #(
   parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         head_valid,
   input  wire spmv_pkg::entry_type          head,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [spmv_pkg::ROW_W-1:0]        rsp_row_number,
   output logic signed [spmv_pkg::VALUE_W-1:0] rsp_row_sum,
   output logic                              rsp_saturated,
   output logic                              rsp_bad_column
);

   import spmv_pkg::*;

   localparam int AW = $clog2(VECTOR_DEPTH);

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] SUM_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] SUM_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   logic                    advance;
   logic [AW+INDEX_W-1:0]   addr_wide;
   logic [AW-1:0]           addr;
   logic                    is_load;
   logic                    is_mac;
   logic signed [VALUE_W-1:0] x_data;

   // stage 1: store read
   logic                      s1_mac_ff, s1_bad_ff, s1_fin_ff;
   logic signed [VALUE_W-1:0] s1_value_ff;
   // stage 2: product
   logic                      s2_mac_ff, s2_bad_ff, s2_fin_ff;
   logic signed [ACC_W-1:0]   s2_prod_ff, s2_prod_in;
   // stage 3: accumulator and finished row
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      err_ff, err_in;
   logic [ROW_W-1:0]          row_ff;
   logic                      s3_fin_ff;
   logic signed [ACC_W-1:0]   s3_sum_ff;
   logic                      s3_err_ff;
   logic [ROW_W-1:0]          s3_row_ff;
   // output register
   logic                      rsp_valid_ff;

   logic signed [ACC_W-1:0]   addend;
   logic [ACC_W:0]            sum_ext;
   logic signed [ACC_W-1:0]   acc_next;
   logic                      sum_fits;
   logic signed [VALUE_W-1:0] clip_value;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign pop       = advance && head_valid;
   assign addr_wide = {{AW{1'b0}}, head.index};
   assign addr      = addr_wide[AW-1:0];
   assign is_load   = pop && (head.kind == KIND_LOAD);
   assign is_mac    = pop && (head.kind == KIND_MAC);

   spmv_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (VECTOR_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (is_load),
      .wr_addr (addr),
      .wr_data (head.value),
      .rd_en   (is_mac),
      .rd_addr (addr),
      .rd_data (x_data)
   );

   assign s2_prod_in = $signed(s1_value_ff) * $signed(x_data);

   // product floored to Q48.16, then saturating 64-bit add
   always_comb begin
      addend   = {{FRAC_W{s2_prod_ff[ACC_W-1]}}, s2_prod_ff[ACC_W-1:FRAC_W]};
      sum_ext  = {acc_ff[ACC_W-1], acc_ff} + {addend[ACC_W-1], addend};
      acc_next = acc_ff;
      if (s2_mac_ff) begin
         if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
            acc_next = sum_ext[ACC_W] ? ACC_MIN : ACC_MAX;
         end else begin
            acc_next = sum_ext[ACC_W-1:0];
         end
      end
      err_in = err_ff || s2_bad_ff;
      acc_in = s2_fin_ff ? '0 : acc_next;
   end

   assign sum_fits   = (&s3_sum_ff[ACC_W-1:VALUE_W-1]) || !(|s3_sum_ff[ACC_W-1:VALUE_W-1]);
   assign clip_value = sum_fits ? s3_sum_ff[VALUE_W-1:0]
                                : (s3_sum_ff[ACC_W-1] ? SUM_MIN : SUM_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_mac_ff    <= 1'b0;
         s1_bad_ff    <= 1'b0;
         s1_fin_ff    <= 1'b0;
         s2_mac_ff    <= 1'b0;
         s2_bad_ff    <= 1'b0;
         s2_fin_ff    <= 1'b0;
         acc_ff       <= '0;
         err_ff       <= 1'b0;
         row_ff       <= '0;
         s3_fin_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_mac_ff    <= is_mac;
         s1_bad_ff    <= pop && (head.kind == KIND_SKIP);
         s1_fin_ff    <= pop && head.fin;
         s2_mac_ff    <= s1_mac_ff;
         s2_bad_ff    <= s1_bad_ff;
         s2_fin_ff    <= s1_fin_ff;
         acc_ff       <= acc_in;
         err_ff       <= s2_fin_ff ? 1'b0 : err_in;
         row_ff       <= s2_fin_ff ? row_ff + 1'b1 : row_ff;
         s3_fin_ff    <= s2_fin_ff;
         rsp_valid_ff <= s3_fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_value_ff    <= head.value;
         s2_prod_ff     <= s2_prod_in;
         s3_sum_ff      <= acc_next;
         s3_err_ff      <= err_in;
         s3_row_ff      <= row_ff;
         rsp_row_number <= s3_row_ff;
         rsp_row_sum    <= clip_value;
         rsp_saturated  <= !sum_fits;
         rsp_bad_column <= s3_err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* sv/csr_sparse_matrix_vector.sv */
// Top level of the CSR sparse matrix-vector multiplier with its register port.
//
//   channel   direction   handshake             payload
//   req_      in          req_valid/req_stall   operation, index, value, row_end
//   rsp_      out         rsp_valid/rsp_stall   row_number, row_sum, saturated, bad_column
//   config    in          psel/penable/pready   paddr, pwdata, prdata (columns_in_use)
//
// One item per cycle sustained while no stalled result freezes the back pipeline: one store
// access and one multiply-accumulate per cycle, the accumulator add closing its loop in acc_ff.
// A row's closing item goes through store read, product and accumulator into the output register.
// A four-item queue sits between front and back.
// Reset is synchronous; the vector store holds no reset value.
// A stalled result freezes the back pipeline; the front keeps taking items until the queue fills.
`default_nettype none

module csr_sparse_matrix_vector #(
   parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [spmv_pkg::OP_W-1:0]       req_operation,
   input  wire logic [spmv_pkg::INDEX_W-1:0]    req_index,
   input  wire logic signed [spmv_pkg::VALUE_W-1:0] req_value,
   input  wire logic                            req_row_end,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [spmv_pkg::ROW_W-1:0]           rsp_row_number,
   output logic signed [spmv_pkg::VALUE_W-1:0]  rsp_row_sum,
   output logic                                 rsp_saturated,
   output logic                                 rsp_bad_column,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [spmv_pkg::PADDR_W-1:0]    paddr,
   input  wire logic [31:0]                     pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   import spmv_pkg::*;

   logic [COLUMNS_W-1:0] columns_ff;
   logic                 reg_hit;
   logic                 push;
   logic                 pop;
   logic                 queue_full;
   logic                 queue_not_empty;
   entry_type            push_entry;
   entry_type            head;

   assign pready  = 1'b1;
   assign reg_hit = paddr[PADDR_W-1] == REG_COLUMNS;
   assign prdata  = reg_hit ? 32'(columns_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         columns_ff <= pwdata[COLUMNS_W-1:0];
      end
   end

   spmv_front #(
      .VECTOR_DEPTH (VECTOR_DEPTH)
   ) u_front (
      .columns_in_use (columns_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_index      (req_index),
      .req_value      (req_value),
      .req_row_end    (req_row_end),
      .queue_full     (queue_full),
      .push           (push),
      .entry          (push_entry)
   );

   spmv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .not_empty  (queue_not_empty),
      .full       (queue_full),
      .head       (head)
   );

   spmv_back #(
      .VECTOR_DEPTH (VECTOR_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (queue_not_empty),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row_number (rsp_row_number),
      .rsp_row_sum    (rsp_row_sum),
      .rsp_saturated  (rsp_saturated),
      .rsp_bad_column (rsp_bad_column)
   );

endmodule

`default_nettype wire

/* bench/row_sum_checker.sv */
`timescale 1ns / 100ps
// Bench checker: tracks accepted items, predicts each row result of the multiplier and compares.
module row_sum_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic [spmv_pkg::OP_W-1:0]           req_operation,
   input  wire logic [spmv_pkg::INDEX_W-1:0]        req_index,
   input  wire logic signed [spmv_pkg::VALUE_W-1:0] req_value,
   input  wire logic                                req_row_end,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic [spmv_pkg::ROW_W-1:0]          rsp_row_number,
   input  wire logic signed [spmv_pkg::VALUE_W-1:0] rsp_row_sum,
   input  wire logic                                rsp_saturated,
   input  wire logic                                rsp_bad_column,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [spmv_pkg::PADDR_W-1:0]        paddr,
   input  wire logic [31:0]                         pwdata,
   input  wire logic [31:0]                         prdata,
   input  wire logic                                pready,
   output int                                       owed_count,
   output int                                       mismatch_count,
   output int                                       rows_checked,
   output int                                       clipped_rows,
   output int                                       flagged_rows
);
   import spmv_pkg::*;

   localparam int REPORT_LIMIT = 40;
   localparam logic [PADDR_W-1:0] COLUMNS_ADDR = {REG_COLUMNS, 2'b00};
   localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint ACC_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;

   typedef struct {
      logic [ROW_W-1:0]   row;
      logic [VALUE_W-1:0] sum;
      logic               sat;
      logic               bad;
   } row_out_type;

   logic [VALUE_W-1:0]   x_store [VECTOR_DEPTH_DEFAULT];
   longint               acc;
   logic [ROW_W-1:0]     row_count;
   logic                 col_err;
   logic [COLUMNS_W-1:0] cols;
   row_out_type          owed_rows [$];
   int                   mismatches;
   int                   checked;
   int                   clipped;
   int                   flagged;

   initial begin
      foreach (x_store[i]) x_store[i] = '0;
   end

   function automatic longint add_clamped(input longint a, input longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         s = a[63] ? ACC_MIN : ACC_MAX;
      end
      return s;
   endfunction

   task automatic close_row();
      row_out_type r;
      r.row = row_count;
      r.bad = col_err;
      if (acc > 64'sd2147483647) begin
         r.sum = 32'h7FFF_FFFF;
         r.sat = 1'b1;
      end else if (acc < -64'sd2147483648) begin
         r.sum = 32'h8000_0000;
         r.sat = 1'b1;
      end else begin
         r.sum = acc[31:0];
         r.sat = 1'b0;
      end
      owed_rows.push_back(r);
      acc       = 0;
      col_err   = 1'b0;
      row_count = row_count + 1'b1;
   endtask

   task automatic take_item(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                            input logic signed [VALUE_W-1:0] val, input logic last);
      logic signed [VALUE_W-1:0] xv;
      longint prod;
      case (op)
         OP_LOAD: begin
            x_store[idx] = val;
         end
         OP_NONZERO: begin
            if ({1'b0, idx} >= cols) begin
               col_err = 1'b1;
            end else begin
               xv   = x_store[idx];
               prod = (longint'(val) * longint'(xv)) >>> FRAC_W;
               acc  = add_clamped(acc, prod);
            end
            if (last) close_row();
         end
         OP_EMPTY: begin
            close_row();
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
      if (got_v !== exp_v) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      row_out_type r;
      if (reset) begin
         acc       = 0;
         row_count = '0;
         col_err   = 1'b0;
         cols      = COLUMNS_RESET;
         owed_rows.delete();
      end else begin
         if (psel && penable && pready && paddr == COLUMNS_ADDR) begin
            if (pwrite) cols = pwdata[COLUMNS_W-1:0];
            else check_field("columns_in_use readback", {19'd0, cols}, prdata);
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_rows.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: row result with none outstanding, expected none, actual %h %h",
                           $time, rsp_row_number, rsp_row_sum);
            end else begin
               r = owed_rows.pop_front();
               check_field("row_number", 32'(r.row), 32'(rsp_row_number));
               check_field("row_sum", r.sum, rsp_row_sum);
               check_field("saturated", 32'(r.sat), 32'(rsp_saturated));
               check_field("bad_column", 32'(r.bad), 32'(rsp_bad_column));
               checked++;
               if (r.sat) clipped++;
               if (r.bad) flagged++;
            end
         end
         if (req_valid && !req_stall)
            take_item(req_operation, req_index, req_value, req_row_end);
      end
      owed_count     <= owed_rows.size();
      mismatch_count <= mismatches;
      rows_checked   <= checked;
      clipped_rows   <= clipped;
      flagged_rows   <= flagged;
   end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Bench top: drives items and register accesses into the multiplier and gives the verdict.
module testbench;
   import spmv_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int SAT_ROW_LENGTH = 4;
   localparam logic [PADDR_W-1:0] COLUMNS_ADDR = {REG_COLUMNS, 2'b00};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OP_W-1:0]           req_operation = '0;
   logic [INDEX_W-1:0]        req_index = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      req_row_end = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b1;
   logic [ROW_W-1:0]          rsp_row_number;
   logic signed [VALUE_W-1:0] rsp_row_sum;
   logic                      rsp_saturated;
   logic                      rsp_bad_column;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [PADDR_W-1:0]        paddr = '0;
   logic [31:0]               pwdata = '0;
   logic [31:0]               prdata;
   logic                      pready;

   int owed_count;
   int mismatch_count;
   int rows_checked;
   int clipped_rows;
   int flagged_rows;

   int send_idle_pct = 32;
   int recv_idle_pct = 52;
   int columns = 4096;
   int items_sent = 0;
   int settings_used = 0;
   int idle_run = 0;
   bit x_written [VECTOR_DEPTH_DEFAULT];
   int x_list [$];

   csr_sparse_matrix_vector dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_index      (req_index),
      .req_value      (req_value),
      .req_row_end    (req_row_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row_number (rsp_row_number),
      .rsp_row_sum    (rsp_row_sum),
      .rsp_saturated  (rsp_saturated),
      .rsp_bad_column (rsp_bad_column),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   row_sum_checker sum_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_index      (req_index),
      .req_value      (req_value),
      .req_row_end    (req_row_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row_number (rsp_row_number),
      .rsp_row_sum    (rsp_row_sum),
      .rsp_saturated  (rsp_saturated),
      .rsp_bad_column (rsp_bad_column),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .owed_count     (owed_count),
      .mismatch_count (mismatch_count),
      .rows_checked   (rows_checked),
      .clipped_rows   (clipped_rows),
      .flagged_rows   (flagged_rows)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_run <= 0;
      end else begin
         idle_run <= idle_run + 1;
         if (idle_run >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, idle_run);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_item(input op_type op, input int idx, input logic [31:0] val,
                            input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_index     <= INDEX_W'(idx);
      req_value     <= val;
      req_row_end   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic load_x(input int idx, input logic [31:0] val, input logic last);
      send_item(OP_LOAD, idx, val, last);
      if (!x_written[idx]) begin
         x_written[idx] = 1'b1;
         x_list.push_back(idx);
      end
   endtask

   // wait until no row is owed and the pipeline has had time to empty
   task automatic settle();
      int quiet;
      quiet = 0;
      req_valid <= 1'b0;
      while (quiet < DRAIN_CYCLES) begin
         @(posedge clock);
         if (owed_count == 0) quiet++;
         else quiet = 0;
      end
   endtask

   task automatic csr_access(input logic write, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= COLUMNS_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_columns(input int v);
      settle();
      csr_access(1'b1, 32'(v));
      csr_access(1'b0, 32'd0);
      columns = v;
      settings_used++;
   endtask

   function automatic logic [31:0] random_value();
      int pick;
      pick = $urandom_range(7);
      if (pick == 0) begin
         case ($urandom_range(4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0001_0000;
         endcase
      end
      if (pick < 4) return $urandom;
      // within +/-4.0 so that most row sums stay in range
      return 32'($urandom_range(32'h7FFFF) - 32'h40000);
   endfunction

   task automatic send_random_item();
      int pick;
      int idx;
      int tries;
      int c;
      logic [31:0] val;
      val  = random_value();
      pick = $urandom_range(99);
      if (pick < 22) begin
         if (columns > 0 && $urandom_range(3) != 0) idx = $urandom_range(columns - 1);
         else idx = $urandom_range(4095);
         load_x(idx, val, $urandom_range(1));
      end else if (pick < 86) begin
         idx = -1;
         if (columns == 0) begin
            idx = $urandom_range(4095);
         end else if (columns < 4096 && $urandom_range(9) == 0) begin
            idx = $urandom_range(4095, columns);
         end else if (x_list.size() > 0) begin
            for (tries = 0; tries < 8 && idx < 0; tries++) begin
               c = x_list[$urandom_range(x_list.size() - 1)];
               if (c < columns) idx = c;
            end
         end
         // no loaded entry in range yet: load one instead
         if (idx < 0) load_x($urandom_range(columns - 1), val, 1'b0);
         else send_item(OP_NONZERO, idx, val, $urandom_range(3) == 0);
      end else if (pick < 94) begin
         send_item(OP_EMPTY, $urandom_range(4095), val, $urandom_range(1));
      end else begin
         send_item(OP_UNUSED, $urandom_range(4095), val, $urandom_range(1));
      end
   endtask

   task automatic run_segment(input int cols, input int count);
      set_columns(cols);
      repeat (count) send_random_item();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, 32'd0);
      set_columns(4096);

      load_x(0, 32'h7FFF_FFFF, 1'b0);
      load_x(4095, 32'h8000_0000, 1'b0);
      load_x(1, 32'h0001_0000, 1'b0);
      load_x(2, 32'hFFFF_0000, 1'b0);
      load_x(3, 32'h0000_0001, 1'b1);
      send_item(OP_NONZERO, 1, 32'h0002_0000, 1'b0);
      send_item(OP_NONZERO, 2, 32'h0001_0000, 1'b0);
      send_item(OP_NONZERO, 3, 32'hFFFF_FFFF, 1'b1);
      send_item(OP_EMPTY, 0, 32'h0, 1'b1);
      send_item(OP_UNUSED, 4095, 32'hFFFF_FFFF, 1'b1);
      send_item(OP_NONZERO, 0, 32'h7FFF_FFFF, 1'b1);
      send_item(OP_NONZERO, 4095, 32'h7FFF_FFFF, 1'b1);
      send_item(OP_NONZERO, 4095, 32'h8000_0000, 1'b1);
      send_item(OP_NONZERO, 1, 32'h0003_0000, 1'b0);
      send_item(OP_EMPTY, 0, 32'h0, 1'b0);
      load_x(6, 32'h0002_8000, 1'b0);
      send_item(OP_NONZERO, 6, 32'h0001_0000, 1'b1);
      set_columns(1);
      send_item(OP_NONZERO, 0, 32'h0001_0000, 1'b0);
      send_item(OP_NONZERO, 1, 32'h0001_0000, 1'b1);
      send_item(OP_NONZERO, 4095, 32'h0001_0000, 1'b1);
      set_columns(0);
      send_item(OP_NONZERO, 0, 32'h0001_0000, 1'b1);
      send_item(OP_NONZERO, 0, 32'h0001_0000, 1'b0);
      send_item(OP_EMPTY, 0, 32'h0, 1'b0);

      run_segment(4096, 300);
      run_segment($urandom_range(4096, 1), 150);

      send_idle_pct = 52;
      recv_idle_pct = 32;
      run_segment(1, 100);
      run_segment($urandom_range(64, 1), 200);
      run_segment(0, 50);
      run_segment(2048, 100);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_segment($urandom_range(4096, 1), 150);
      run_segment(4096, 250);

      // one short row whose sum runs well past the 32-bit result range
      load_x(7, 32'h8000_0000, 1'b0);
      repeat (SAT_ROW_LENGTH - 1) send_item(OP_NONZERO, 7, 32'h8000_0000, 1'b0);
      send_item(OP_NONZERO, 7, 32'h8000_0000, 1'b1);
      send_item(OP_NONZERO, 1, 32'h0001_0000, 1'b1);

      settle();
      $display("Sent %0d items under %0d column settings; %0d row results checked.",
               items_sent, settings_used, rows_checked);
      $display("Rows clipped to range: %0d; rows with an out-of-range column: %0d.",
               clipped_rows, flagged_rows);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* csr_sparse_matrix_vector.f */
sv/spmv_pkg.sv
sv/spmv_ram.sv
sv/spmv_front.sv
sv/spmv_queue.sv
sv/spmv_back.sv
sv/csr_sparse_matrix_vector.sv
bench/row_sum_checker.sv
bench/testbench.sv
